>>> rtl/hsd_pkg.sv
package hsd_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int RING_SLOTS      = 64;

  localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int SLOT_W = $clog2(RING_SLOTS);
  localparam int PKT_W  = 10;
  localparam int PPB_W  = 11;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [PPB_W-1:0] PPB_MAX = PPB_W'(1024);

  typedef enum logic [2:0] {
    REG_START_FLAG   = 3'd0,
    REG_END_FLAG     = 3'd1,
    REG_ESCAPE_BYTE  = 3'd2,
    REG_UNSTUFF_MASK = 3'd3,
    REG_PIPE_ID      = 3'd4,
    REG_PPB          = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    FK_NONE = 2'd0,
    FK_ID   = 2'd1,
    FK_CTL  = 2'd2,
    FK_PIPE = 2'd3
  } frame_kind_t;

  typedef struct packed {
    logic [7:0]       start_flag;
    logic [7:0]       end_flag;
    logic [7:0]       escape_byte;
    logic [7:0]       unstuff_mask;
    logic [7:0]       pipe_id;
    logic [PPB_W-1:0] packets_per_block;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart_ring;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic       channel;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [8:0] frame_length;
    logic       overflowed;
    logic [5:0] ring_slot;
    logic       block_done;
    logic [5:0] block_start_slot;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

>>> rtl/hdlc_style_rx_deframer_top.sv
// receive deframer for an hdlc-style byte stream
// in channel: one raw byte per transfer (in_item.rx_byte), with restart_ring
//   clearing the ring slot, block start and packet count before the byte
// out channel: zero or one result per input byte: a payload byte with its
//   channel and index, or a frame end with length, overflow, ring slot and
//   block completion
// cfg port: apb-style, registers at byte address 4*i, read back as written;
//   write only while no transfer is in flight
// latency: a byte taken at one clock edge yields its result in the output
//   register at the next edge, so out_valid rises one cycle after the in
//   transfer
// throughput: one byte per cycle, set by the single pass of compare and
//   count logic between the input register and the output register
// stall: while out_stall holds a result, the next byte waits in the input
//   register and in_stall rises; once both registers are full nothing more
//   is taken
// reset: synchronous, clears frame state, ring state, both valid flags and
//   loads the configuration defaults
module hdlc_style_rx_deframer_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  hsd_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output hsd_pkg::out_item_t        out_item,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [hsd_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [hsd_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [hsd_pkg::DATA_W-1:0] cfg_prdata,
  output logic                      cfg_pready
);

  hsd_pkg::cfg_t     cfg;
  hsd_pkg::result_t  res;
  hsd_pkg::in_item_t hold_r;
  logic              hold_valid_r, hold_valid_nxt;
  logic              out_ready;
  logic              step;
  logic              accept;

  assign step     = hold_valid_r && out_ready;
  assign in_stall = hold_valid_r && !out_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (step) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= in_item;
    end
  end

  hsd_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  hsd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (step),
    .item  (hold_r),
    .res   (res)
  );

  hsd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !res.valid)
    else $error("result register overwritten while stalled");

  a_stall_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (hold_valid_r && out_valid && out_stall))
    else $error("input stalled without a pending result");

  a_step_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> out_valid)
    else $error("result not registered");

  a_block_done_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.block_done) |-> (out_item.kind && out_item.channel))
    else $error("block completion outside a pipe frame end");

endmodule

>>> rtl/hsd_cfg_regs.sv
module hsd_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [hsd_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [hsd_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [hsd_pkg::DATA_W-1:0] cfg_prdata,
  output logic                      cfg_pready,
  output hsd_pkg::cfg_t             cfg
);

  hsd_pkg::cfg_t    cfg_r;
  hsd_pkg::cfg_t    cfg_nxt;
  hsd_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx        = hsd_pkg::reg_idx_t'(cfg_paddr[hsd_pkg::ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        hsd_pkg::REG_START_FLAG:   cfg_nxt.start_flag   = cfg_pwdata[7:0];
        hsd_pkg::REG_END_FLAG:     cfg_nxt.end_flag     = cfg_pwdata[7:0];
        hsd_pkg::REG_ESCAPE_BYTE:  cfg_nxt.escape_byte  = cfg_pwdata[7:0];
        hsd_pkg::REG_UNSTUFF_MASK: cfg_nxt.unstuff_mask = cfg_pwdata[7:0];
        hsd_pkg::REG_PIPE_ID:      cfg_nxt.pipe_id      = cfg_pwdata[7:0];
        hsd_pkg::REG_PPB: begin
          cfg_nxt.packets_per_block = cfg_pwdata[hsd_pkg::PPB_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      hsd_pkg::REG_START_FLAG:   cfg_prdata = 32'(cfg_r.start_flag);
      hsd_pkg::REG_END_FLAG:     cfg_prdata = 32'(cfg_r.end_flag);
      hsd_pkg::REG_ESCAPE_BYTE:  cfg_prdata = 32'(cfg_r.escape_byte);
      hsd_pkg::REG_UNSTUFF_MASK: cfg_prdata = 32'(cfg_r.unstuff_mask);
      hsd_pkg::REG_PIPE_ID:      cfg_prdata = 32'(cfg_r.pipe_id);
      hsd_pkg::REG_PPB:          cfg_prdata = 32'(cfg_r.packets_per_block);
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_flag        <= 8'd126;
      cfg_r.end_flag          <= 8'd125;
      cfg_r.escape_byte       <= 8'd124;
      cfg_r.unstuff_mask      <= 8'd32;
      cfg_r.pipe_id           <= 8'd0;
      cfg_r.packets_per_block <= hsd_pkg::PPB_W'(16);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/hsd_core.sv
module hsd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  hsd_pkg::cfg_t     cfg,
  input  logic              step,
  input  hsd_pkg::in_item_t item,
  output hsd_pkg::result_t  res
);

  logic                        in_frame_r, in_frame_nxt;
  logic                        esc_r, esc_nxt;
  logic                        ovf_r, ovf_nxt;
  hsd_pkg::frame_kind_t        fk_r, fk_nxt;
  logic [hsd_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [hsd_pkg::SLOT_W-1:0]  head_r, head_nxt;
  logic [hsd_pkg::SLOT_W-1:0]  bstart_r, bstart_nxt;
  logic [hsd_pkg::PKT_W-1:0]   pkt_r, pkt_nxt;

  logic [7:0]                  b;
  logic [hsd_pkg::SLOT_W-1:0]  head_eff, bstart_eff, head_wrap;
  logic [hsd_pkg::SLOT_W:0]    head_inc;
  logic [hsd_pkg::PKT_W-1:0]   pkt_eff;
  logic [hsd_pkg::PPB_W-1:0]   ppb_eff, pkt_next;
  logic                        do_store, store_pipe;
  logic [7:0]                  store_byte;

  assign b = item.rx_byte;

  always_comb begin
    head_eff   = item.restart_ring ? '0 : head_r;
    bstart_eff = item.restart_ring ? '0 : bstart_r;
    pkt_eff    = item.restart_ring ? '0 : pkt_r;

    head_inc  = {1'b0, head_eff} + 1'b1;
    head_wrap = (head_inc >= (hsd_pkg::SLOT_W + 1)'(hsd_pkg::RING_SLOTS)) ?
                '0 : head_inc[hsd_pkg::SLOT_W-1:0];

    if (cfg.packets_per_block == '0) begin
      ppb_eff = hsd_pkg::PPB_W'(1);
    end else if (cfg.packets_per_block > hsd_pkg::PPB_MAX) begin
      ppb_eff = hsd_pkg::PPB_MAX;
    end else begin
      ppb_eff = cfg.packets_per_block;
    end
    pkt_next = hsd_pkg::PPB_W'(pkt_eff) + 1'b1;

    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    ovf_nxt      = ovf_r;
    fk_nxt       = fk_r;
    cnt_nxt      = cnt_r;
    head_nxt     = head_eff;
    bstart_nxt   = bstart_eff;
    pkt_nxt      = pkt_eff;
    do_store     = 1'b0;
    store_pipe   = 1'b0;
    store_byte   = b;
    res          = '0;

    if (in_frame_r && b == cfg.end_flag) begin
      in_frame_nxt = 1'b0;
      esc_nxt      = 1'b0;
      fk_nxt       = hsd_pkg::FK_NONE;
      case (fk_r)
        hsd_pkg::FK_CTL: begin
          res.valid             = 1'b1;
          res.item.kind         = 1'b1;
          res.item.frame_length = 9'(cnt_r);
          res.item.overflowed   = ovf_r;
        end
        hsd_pkg::FK_PIPE: begin
          res.valid             = 1'b1;
          res.item.kind         = 1'b1;
          res.item.channel      = 1'b1;
          res.item.frame_length = 9'(cnt_r);
          res.item.overflowed   = ovf_r;
          res.item.ring_slot    = 6'(head_eff);
          head_nxt              = head_wrap;
          if (pkt_next >= ppb_eff) begin
            pkt_nxt                   = '0;
            res.item.block_done       = 1'b1;
            res.item.block_start_slot = 6'(bstart_eff);
            bstart_nxt                = head_wrap;
          end else begin
            pkt_nxt = pkt_next[hsd_pkg::PKT_W-1:0];
          end
        end
        default: ;
      endcase
    end else if (b == cfg.start_flag) begin
      in_frame_nxt = 1'b1;
      esc_nxt      = 1'b0;
      ovf_nxt      = 1'b0;
      fk_nxt       = hsd_pkg::FK_ID;
      cnt_nxt      = '0;
    end else if (in_frame_r) begin
      if (fk_r == hsd_pkg::FK_ID) begin
        store_pipe = (b == cfg.pipe_id);
        fk_nxt     = store_pipe ? hsd_pkg::FK_PIPE : hsd_pkg::FK_CTL;
        do_store   = 1'b1;
      end else if (b == cfg.escape_byte) begin
        esc_nxt = 1'b1;
      end else begin
        store_pipe = (fk_r == hsd_pkg::FK_PIPE);
        do_store   = 1'b1;
        if (esc_r) begin
          esc_nxt    = 1'b0;
          store_byte = b ^ cfg.unstuff_mask;
        end
      end
    end

    if (do_store) begin
      if (cnt_r >= hsd_pkg::CNT_W'(hsd_pkg::MAX_FRAME_BYTES)) begin
        ovf_nxt = 1'b1;
      end else begin
        res.valid             = 1'b1;
        res.item.channel      = store_pipe;
        res.item.payload_byte = store_byte;
        res.item.byte_index   = 8'(cnt_r);
        res.item.ring_slot    = store_pipe ? 6'(head_eff) : 6'd0;
        cnt_nxt               = cnt_r + 1'b1;
      end
    end

    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      ovf_r      <= 1'b0;
      fk_r       <= hsd_pkg::FK_NONE;
      cnt_r      <= '0;
      head_r     <= '0;
      bstart_r   <= '0;
      pkt_r      <= '0;
    end else if (step) begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      ovf_r      <= ovf_nxt;
      fk_r       <= fk_nxt;
      cnt_r      <= cnt_nxt;
      head_r     <= head_nxt;
      bstart_r   <= bstart_nxt;
      pkt_r      <= pkt_nxt;
    end
  end

endmodule

>>> rtl/hsd_out_stage.sv
module hsd_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  hsd_pkg::result_t   res,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_stall,
  output hsd_pkg::out_item_t out_item
);

  logic               valid_r, valid_nxt;
  hsd_pkg::out_item_t item_r;

  assign ready     = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      item_r <= res.item;
    end
  end

endmodule

>>> tb/hsd_frame_checker.sv
module hsd_frame_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  hsd_pkg::in_item_t          in_item,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  hsd_pkg::out_item_t         out_item,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [hsd_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [hsd_pkg::DATA_W-1:0] cfg_pwdata,
  input  logic [hsd_pkg::DATA_W-1:0] cfg_prdata,
  input  logic                       cfg_pready,
  output int unsigned                results_due,
  output int unsigned                fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import hsd_pkg::*;

  // configuration copy
  logic [7:0]       start_flag_r;
  logic [7:0]       end_flag_r;
  logic [7:0]       escape_r;
  logic [7:0]       mask_r;
  logic [7:0]       pipe_id_r;
  logic [PPB_W-1:0] ppb_r;

  // deframer state
  logic              in_frame;
  logic              esc_pend;
  logic              ovf_seen;
  frame_kind_t       fkind;
  logic [CNT_W-1:0]  nbytes;
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] blk_start;
  logic [PKT_W-1:0]  pkt_cnt;

  out_item_t due_results[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic store_payload(input logic [7:0] v, output bit got, output out_item_t r);
    bit pipe;
    pipe = (fkind == FK_PIPE);
    r = '0;
    got = 1'b0;
    if (nbytes >= CNT_W'(MAX_FRAME_BYTES)) begin
      ovf_seen = 1'b1;
    end else begin
      r.channel      = pipe;
      r.payload_byte = v;
      r.byte_index   = nbytes[7:0];
      r.ring_slot    = pipe ? head : '0;
      got            = 1'b1;
      nbytes         = nbytes + 1'b1;
    end
  endtask

  task automatic deframe_byte(input in_item_t it, output bit got, output out_item_t r);
    logic [7:0]       b;
    logic [PPB_W-1:0] eff;
    logic [PKT_W:0]   nxt;
    frame_kind_t      was;
    b = it.rx_byte;
    got = 1'b0;
    r = '0;
    if (it.restart_ring) begin
      head      = '0;
      blk_start = '0;
      pkt_cnt   = '0;
    end
    if (in_frame && b == end_flag_r) begin
      was      = fkind;
      in_frame = 1'b0;
      esc_pend = 1'b0;
      fkind    = FK_NONE;
      if (was == FK_CTL || was == FK_PIPE) begin
        got            = 1'b1;
        r.kind         = 1'b1;
        r.frame_length = nbytes;
        r.overflowed   = ovf_seen;
        if (was == FK_PIPE) begin
          r.channel   = 1'b1;
          r.ring_slot = head;
          if (ppb_r == '0) begin
            eff = PPB_W'(1);
          end else if (ppb_r > PPB_MAX) begin
            eff = PPB_MAX;
          end else begin
            eff = ppb_r;
          end
          nxt  = {1'b0, pkt_cnt} + 1'b1;
          head = (int'(head) + 1 >= RING_SLOTS) ? '0 : head + 1'b1;
          if (PPB_W'(nxt) >= eff) begin
            pkt_cnt            = '0;
            r.block_done       = 1'b1;
            r.block_start_slot = blk_start;
            blk_start          = head;
          end else begin
            pkt_cnt = nxt[PKT_W-1:0];
          end
        end
      end
    end else if (b == start_flag_r) begin
      in_frame = 1'b1;
      esc_pend = 1'b0;
      ovf_seen = 1'b0;
      fkind    = FK_ID;
      nbytes   = '0;
    end else if (in_frame) begin
      if (fkind == FK_ID) begin
        fkind = (b == pipe_id_r) ? FK_PIPE : FK_CTL;
        store_payload(b, got, r);
      end else if (b == escape_r) begin
        esc_pend = 1'b1;
      end else if (esc_pend) begin
        esc_pend = 1'b0;
        store_payload(b ^ mask_r, got, r);
      end else begin
        store_payload(b, got, r);
      end
    end
  endtask

  always @(posedge clk) begin
    bit               got;
    out_item_t        r;
    out_item_t        want;
    logic [DATA_W-1:0] rd;
    bit               known;
    reg_idx_t         idx;
    if (!rst_n) begin
      start_flag_r = 8'h7E;
      end_flag_r   = 8'h7D;
      escape_r     = 8'h7C;
      mask_r       = 8'h20;
      pipe_id_r    = 8'h00;
      ppb_r        = PPB_W'(16);
      in_frame     = 1'b0;
      esc_pend     = 1'b0;
      ovf_seen     = 1'b0;
      fkind        = FK_NONE;
      nbytes       = '0;
      head         = '0;
      blk_start    = '0;
      pkt_cnt      = '0;
      fail_count   = 0;
      due_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        idx = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);
        if (cfg_pwrite) begin
          case (idx)
            REG_START_FLAG:   start_flag_r = cfg_pwdata[7:0];
            REG_END_FLAG:     end_flag_r   = cfg_pwdata[7:0];
            REG_ESCAPE_BYTE:  escape_r     = cfg_pwdata[7:0];
            REG_UNSTUFF_MASK: mask_r       = cfg_pwdata[7:0];
            REG_PIPE_ID:      pipe_id_r    = cfg_pwdata[7:0];
            REG_PPB:          ppb_r        = cfg_pwdata[PPB_W-1:0];
            default: ;
          endcase
        end else begin
          known = 1'b1;
          rd = '0;
          case (idx)
            REG_START_FLAG:   rd = DATA_W'(start_flag_r);
            REG_END_FLAG:     rd = DATA_W'(end_flag_r);
            REG_ESCAPE_BYTE:  rd = DATA_W'(escape_r);
            REG_UNSTUFF_MASK: rd = DATA_W'(mask_r);
            REG_PIPE_ID:      rd = DATA_W'(pipe_id_r);
            REG_PPB:          rd = DATA_W'(ppb_r);
            default:          known = 1'b0;
          endcase
          if (known && cfg_prdata !== rd) report("register read", cfg_prdata, rd);
        end
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report("result with nothing due", 1, 0);
        end else begin
          want = due_results.pop_front();
          if (out_item.kind !== want.kind) report("kind", out_item.kind, want.kind);
          if (out_item.channel !== want.channel) report("channel", out_item.channel, want.channel);
          if (out_item.payload_byte !== want.payload_byte)
            report("payload_byte", out_item.payload_byte, want.payload_byte);
          if (out_item.byte_index !== want.byte_index)
            report("byte_index", out_item.byte_index, want.byte_index);
          if (out_item.frame_length !== want.frame_length)
            report("frame_length", out_item.frame_length, want.frame_length);
          if (out_item.overflowed !== want.overflowed)
            report("overflowed", out_item.overflowed, want.overflowed);
          if (out_item.ring_slot !== want.ring_slot)
            report("ring_slot", out_item.ring_slot, want.ring_slot);
          if (out_item.block_done !== want.block_done)
            report("block_done", out_item.block_done, want.block_done);
          if (out_item.block_start_slot !== want.block_start_slot)
            report("block_start_slot", out_item.block_start_slot, want.block_start_slot);
        end
      end
      if (in_valid && !in_stall) begin
        deframe_byte(in_item, got, r);
        if (got) due_results.push_back(r);
      end
    end
    results_due <= due_results.size();
  end

endmodule

>>> tb/tb_hdlc_style_rx_deframer_top.sv
module tb_hdlc_style_rx_deframer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hsd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_item;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]  cfg_paddr = '0;
  logic [DATA_W-1:0]  cfg_pwdata = '0;
  logic [DATA_W-1:0]  cfg_prdata;
  logic               cfg_pready;

  int unsigned results_due;
  int unsigned fail_count;
  int          cycles = 0;
  int          hold_left = 0;
  int          sent_count = 0;
  int          tx_idle = 2;
  int          rx_idle = 2;
  int          restart_pct = 0;

  // framing bytes currently programmed, for building stimulus
  logic [7:0] cur_start = 8'h7E;
  logic [7:0] cur_end = 8'h7D;
  logic [7:0] cur_esc = 8'h7C;
  logic [7:0] cur_mask = 8'h20;
  logic [7:0] cur_pid = 8'h00;

  hdlc_style_rx_deframer_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  hsd_frame_checker i_frame_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .results_due (results_due),
    .fail_count  (fail_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // 0: never wait, 1: always draw, 2: mostly back to back
  function automatic int draw_wait(input int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 19);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
  endfunction

  // result side: after each transfer, hold out_stall for a wait drawn by draw_wait
  always @(posedge clk) begin
    int n;
    if (out_valid && !out_stall) begin
      n = draw_wait(rx_idle);
      hold_left <= n;
      out_stall <= (n != 0);
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end
  end

  task automatic send(input logic [7:0] b, input bit restart);
    int       gap;
    in_item_t it;
    gap = draw_wait(tx_idle);
    it.rx_byte = b;
    it.restart_ring = restart | ($urandom_range(0, 99) < restart_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_access(input bit wr, input reg_idx_t idx, input logic [DATA_W-1:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wr ? val : '0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x,
                            input logic [7:0] m, input logic [7:0] p,
                            input logic [PPB_W-1:0] ppb);
    drain();
    cfg_access(1'b1, REG_START_FLAG, DATA_W'(s));
    cfg_access(1'b1, REG_END_FLAG, DATA_W'(e));
    cfg_access(1'b1, REG_ESCAPE_BYTE, DATA_W'(x));
    cfg_access(1'b1, REG_UNSTUFF_MASK, DATA_W'(m));
    cfg_access(1'b1, REG_PIPE_ID, DATA_W'(p));
    cfg_access(1'b1, REG_PPB, DATA_W'(ppb));
    for (int i = REG_START_FLAG; i <= REG_PPB; i++) cfg_access(1'b0, reg_idx_t'(i), '0);
    cur_start = s;
    cur_end = e;
    cur_esc = x;
    cur_mask = m;
    cur_pid = p;
  endtask

  task automatic random_config();
    logic [7:0]       s;
    logic [7:0]       e;
    logic [7:0]       x;
    logic [7:0]       p;
    logic [PPB_W-1:0] ppb;
    s = 8'($urandom);
    do e = 8'($urandom); while (e == s);
    do x = 8'($urandom); while (x == s || x == e);
    do p = 8'($urandom); while (p == s || p == e);
    ppb = $urandom_range(0, 1) ? PPB_W'($urandom_range(1, 8)) : PPB_W'($urandom_range(1, 1024));
    set_config(s, e, x, 8'($urandom), p, ppb);
  endtask

  task automatic send_frame(input bit pipe, input int len);
    logic [7:0] v;
    send(cur_start, 1'b0);
    if (pipe) begin
      v = cur_pid;
    end else begin
      do v = 8'($urandom); while (v == cur_pid || v == cur_start || v == cur_end);
    end
    send(v, 1'b0);
    for (int k = 0; k < len; k++) begin
      v = 8'($urandom);
      if (v == cur_start || v == cur_end || v == cur_esc || $urandom_range(0, 15) == 0) begin
        send(cur_esc, 1'b0);
        send(v ^ cur_mask, 1'b0);
      end else begin
        send(v, 1'b0);
      end
    end
    send(cur_end, 1'b0);
  endtask

  task automatic random_part(input int count);
    int goal;
    int pick;
    goal = sent_count + count;
    while (sent_count < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_frame($urandom_range(0, 1),
                   ($urandom_range(0, 99) == 0) ? $urandom_range(250, 270)
                                                : $urandom_range(0, 12));
      end else if (pick < 85) begin
        // stray bytes between frames
        repeat ($urandom_range(1, 4)) send(8'($urandom), 1'b0);
      end else if (pick < 92) begin
        // frame cut short by a new start or by an escape before the end
        send(cur_start, 1'b0);
        send(8'($urandom), 1'b0);
        repeat ($urandom_range(0, 4)) send(8'($urandom), 1'b0);
        if ($urandom_range(0, 1)) begin
          send(cur_start, 1'b0);
        end else begin
          send(cur_esc, 1'b0);
          send(cur_end, 1'b0);
        end
      end else if (pick < 96) begin
        send(cur_start, 1'b0);
        send(cur_end, 1'b0);
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // power-up framing bytes
    send(8'h00, 1'b1);
    send(8'hFF, 1'b0);
    send(8'h7E, 1'b0);
    send(8'h7D, 1'b0);
    send(8'h7E, 1'b0);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(8'h7C, 1'b0);
    send(8'h7C, 1'b0);
    send(8'h5D, 1'b0);
    send(8'h7D, 1'b0);
    send(8'h7E, 1'b0);
    send(8'h7C, 1'b0);
    send(8'h7C, 1'b0);
    send(8'h7D, 1'b0);
    send(8'h7E, 1'b0);
    send(8'h11, 1'b0);
    send(8'h22, 1'b0);
    send(8'h7E, 1'b0);
    send(8'h00, 1'b1);
    send(8'h7C, 1'b0);
    send(8'h5E, 1'b0);
    send(8'h7D, 1'b0);

    // buffer exactly full, then overfull
    send_frame(1'b1, 255);
    send_frame(1'b0, 258);
    random_part(170);

    set_config(8'h00, 8'hFF, 8'h80, 8'hFF, 8'h01, PPB_W'(1));
    tx_idle = 1;
    rx_idle = 0;
    random_part(170);

    set_config(8'hFF, 8'h00, 8'h01, 8'h00, 8'h7E, PPB_MAX);
    tx_idle = 0;
    rx_idle = 1;
    restart_pct = 2;
    random_part(170);

    set_config(8'h7E, 8'h7D, 8'h7C, 8'h55, 8'hAA, PPB_W'(0));
    tx_idle = 1;
    rx_idle = 1;
    restart_pct = 0;
    random_part(170);

    set_config(8'h10, 8'h20, 8'h30, 8'h80, 8'hFE, {PPB_W{1'b1}});
    tx_idle = 0;
    rx_idle = 0;
    random_part(170);

    // enough short pipe frames to wrap the ring
    set_config(8'h7E, 8'h7D, 8'h7C, 8'h20, 8'h00, PPB_W'(2));
    tx_idle = 2;
    rx_idle = 2;
    repeat (70) send_frame(1'b1, $urandom_range(0, 2));
    random_part(170);

    random_config();
    tx_idle = 2;
    rx_idle = 1;
    restart_pct = 1;
    random_part(170);

    random_config();
    tx_idle = 1;
    rx_idle = 2;
    restart_pct = 0;
    random_part(170);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
